FILE: sv/assert_macros.svh
// Assertion macros shared by the thinning block RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/gkt_pkg.sv
// Shared constants and types for the greedy keypoint thinning block.
// No dependencies.
package gkt_pkg;

    localparam int COORD_W            = 16;
    localparam int INDEX_W            = 16;
    localparam int THRESH_W           = 33;
    localparam int DIST_W             = 34;
    localparam int ENTRY_W            = 2 * COORD_W;
    localparam int MAX_SURVIVORS_DEF  = 64;

    localparam logic [INDEX_W-1:0]  INDEX_MAX    = '1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(25600);

    // Step enables from the sequencer to the distance unit.
    typedef struct packed {
        logic diff_en;
        logic sq_x_en;
        logic sq_y_en;
    } t_dist_ctrl;

endpackage

FILE: sv/gkt_point_if.sv
// Request channel carrying one keypoint into the thinning block.
// Depends on gkt_pkg.
interface gkt_point_if;
    logic                         valid;
    logic                         ready;
    logic                         start_req;
    logic [gkt_pkg::COORD_W-1:0]  pos_x;
    logic [gkt_pkg::COORD_W-1:0]  pos_y;

    modport source (output valid, start_req, pos_x, pos_y, input ready);
    modport sink   (input valid, start_req, pos_x, pos_y, output ready);
endinterface

FILE: sv/gkt_kept_if.sv
// Request channel carrying one kept keypoint out of the thinning block.
// Depends on gkt_pkg.
interface gkt_kept_if;
    logic                         valid;
    logic                         ready;
    logic [gkt_pkg::COORD_W-1:0]  kept_x;
    logic [gkt_pkg::COORD_W-1:0]  kept_y;
    logic [gkt_pkg::INDEX_W-1:0]  point_index;
    logic                         store_full;

    modport source (output valid, kept_x, kept_y, point_index, store_full, input ready);
    modport sink   (input valid, kept_x, kept_y, point_index, store_full, output ready);
endinterface

FILE: sv/gkt_dist_unit.sv
// Shared squared-distance unit: one 16x16 squarer used for dx then dy.
// Depends on gkt_pkg.
module gkt_dist_unit (
    input  logic                          i_clk,
    input  gkt_pkg::t_dist_ctrl           i_ctrl,
    input  logic [gkt_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [gkt_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [gkt_pkg::ENTRY_W-1:0]   i_entry,
    input  logic [gkt_pkg::THRESH_W-1:0]  i_thresh,
    output logic                          o_far
);
    localparam int CW = gkt_pkg::COORD_W;
    localparam int PW = 2 * gkt_pkg::COORD_W;

    logic [CW-1:0] r_dx;
    logic [CW-1:0] r_dy;
    logic [PW-1:0] r_acc;
    logic [PW-1:0] r_prod;
    logic [CW-1:0] ref_x;
    logic [CW-1:0] ref_y;
    logic [CW-1:0] sq_op;
    logic [PW-1:0] sq_res;
    logic [gkt_pkg::DIST_W-1:0] sq_sum;

    assign ref_x  = i_entry[PW-1:CW];
    assign ref_y  = i_entry[CW-1:0];
    assign sq_op  = i_ctrl.sq_y_en ? r_dy : r_dx;
    assign sq_res = PW'(sq_op) * PW'(sq_op);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.diff_en) begin
            r_dx <= (i_pos_x >= ref_x) ? (i_pos_x - ref_x) : (ref_x - i_pos_x);
            r_dy <= (i_pos_y >= ref_y) ? (i_pos_y - ref_y) : (ref_y - i_pos_y);
        end
        if (i_ctrl.sq_x_en) begin
            r_acc <= sq_res;
        end
        if (i_ctrl.sq_y_en) begin
            r_prod <= sq_res;
        end
    end

    assign sq_sum = gkt_pkg::DIST_W'(r_acc) + gkt_pkg::DIST_W'(r_prod);
    assign o_far  = sq_sum >= gkt_pkg::DIST_W'(i_thresh);

endmodule

FILE: sv/greedy_keypoint_thinning_top.sv
// Greedy keypoint thinning: a point is kept if its squared distance to every stored
// survivor of its set is at least the threshold. Each of up to MAX_SURVIVORS survivors
// passes the shared squarer through fetch, difference, square dx, square dy and compare;
// a kept point then waits in decide while the output register is held by the receiver.
// The block takes no new point until the current one is kept or dropped.
// Synchronous active-low reset clears sequencer, count, index, output valid; threshold 25600.
`include "assert_macros.svh"

module greedy_keypoint_thinning_top #(
    parameter int MAX_SURVIVORS = gkt_pkg::MAX_SURVIVORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gkt_pkg::THRESH_W-1:0]  i_cfg_wr_data,
    gkt_point_if.sink                     i_pt,
    gkt_kept_if.source                    o_kept
);
    localparam int AW = (MAX_SURVIVORS > 1) ? $clog2(MAX_SURVIVORS) : 1;
    localparam int NW = $clog2(MAX_SURVIVORS + 1);
    localparam int CW = gkt_pkg::COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_CMP,
        S_DECIDE
    } t_state;

    t_state                        r_state;
    logic [gkt_pkg::THRESH_W-1:0]  r_thresh;
    logic [NW-1:0]                 r_count;
    logic [NW-1:0]                 r_i;
    logic [gkt_pkg::INDEX_W-1:0]   r_set_index;
    logic [gkt_pkg::INDEX_W-1:0]   r_cur_index;
    logic [CW-1:0]                 r_x;
    logic [CW-1:0]                 r_y;
    logic [gkt_pkg::ENTRY_W-1:0]   r_entry;
    logic [gkt_pkg::ENTRY_W-1:0]   r_mem [MAX_SURVIVORS];
    logic                          r_out_valid;
    logic [CW-1:0]                 r_out_x;
    logic [CW-1:0]                 r_out_y;
    logic [gkt_pkg::INDEX_W-1:0]   r_out_index;
    logic                          r_out_full;

    logic [NW-1:0]                 n_count;
    logic [gkt_pkg::INDEX_W-1:0]   n_set_index;
    logic [NW-1:0]                 n_i;
    gkt_pkg::t_dist_ctrl           dist_ctrl;
    logic                          far;
    logic                          pt_acc;
    logic                          out_free;
    logic                          has_room;

    assign pt_acc   = i_pt.valid && i_pt.ready;
    assign out_free = !r_out_valid || o_kept.ready;
    assign has_room = r_count < NW'(MAX_SURVIVORS);
    assign n_i      = r_i + NW'(1);

    // A start request clears the set before this point is handled.
    assign n_count     = i_pt.start_req ? '0 : r_count;
    assign n_set_index = i_pt.start_req ? '0 : r_set_index;

    assign dist_ctrl.diff_en = (r_state == S_DIFF);
    assign dist_ctrl.sq_x_en = (r_state == S_SQX);
    assign dist_ctrl.sq_y_en = (r_state == S_SQY);

    gkt_dist_unit u_dist (
        .i_clk    (i_clk),
        .i_ctrl   (dist_ctrl),
        .i_pos_x  (r_x),
        .i_pos_y  (r_y),
        .i_entry  (r_entry),
        .i_thresh (r_thresh),
        .o_far    (far)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_entry <= r_mem[r_i[AW-1:0]];
        end
        if (r_state == S_DECIDE && out_free && has_room) begin
            r_mem[r_count[AW-1:0]] <= {r_x, r_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thresh    <= gkt_pkg::THRESH_RESET;
            r_count     <= '0;
            r_i         <= '0;
            r_set_index <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            // S_DECIDE reloads the output register itself
            if (o_kept.valid && o_kept.ready && r_state != S_DECIDE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pt_acc) begin
                        r_x         <= i_pt.pos_x;
                        r_y         <= i_pt.pos_y;
                        r_count     <= n_count;
                        r_cur_index <= n_set_index;
                        r_set_index <= (n_set_index == gkt_pkg::INDEX_MAX) ?
                                       n_set_index : n_set_index + 1'b1;
                        r_i         <= '0;
                        r_state     <= (n_count == '0) ? S_DECIDE : S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_DIFF;
                S_DIFF:  r_state <= S_SQX;
                S_SQX:   r_state <= S_SQY;
                S_SQY:   r_state <= S_CMP;
                S_CMP: begin
                    if (!far) begin
                        // drop: too close to a survivor
                        r_state <= S_IDLE;
                    end else if (n_i == r_count) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_i     <= n_i;
                        r_state <= S_FETCH;
                    end
                end
                S_DECIDE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_x;
                        r_out_y     <= r_y;
                        r_out_index <= r_cur_index;
                        r_out_full  <= !has_room;
                        if (has_room) begin
                            r_count <= r_count + NW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pt.ready         = (r_state == S_IDLE);
    assign o_kept.valid       = r_out_valid;
    assign o_kept.kept_x      = r_out_x;
    assign o_kept.kept_y      = r_out_y;
    assign o_kept.point_index = r_out_index;
    assign o_kept.store_full  = r_out_full;

    `ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NW'(MAX_SURVIVORS))
    `ASSERT_IMPLIES(a_cmp_in_range, i_clk, i_rst_n, r_state == S_CMP, r_i < r_count)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, pt_acc, r_state != S_IDLE)
    `ASSERT_IMPLIES(a_out_from_decide, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DECIDE)

endmodule

FILE: tb/tb_greedy_keypoint_thinning_top.sv
// Self-checking bench for greedy_keypoint_thinning_top: a table of directed points, mostly
// with typed-in outcomes, then random point sets under several thresholds, idle patterns and
// back-pressure, scored against an in-bench survivor predictor. Depends on gkt_pkg, gkt_point_if and gkt_kept_if.
module tb_greedy_keypoint_thinning_top;

    localparam int                     COORD_W      = gkt_pkg::COORD_W;
    localparam int                     INDEX_W      = gkt_pkg::INDEX_W;
    localparam int                     THRESH_W     = gkt_pkg::THRESH_W;
    localparam int                     ENTRY_W      = gkt_pkg::ENTRY_W;
    localparam int                     DIST_W       = gkt_pkg::DIST_W;
    localparam bit [INDEX_W-1:0]       INDEX_MAX    = gkt_pkg::INDEX_MAX;
    localparam bit [THRESH_W-1:0]      THRESH_RESET = gkt_pkg::THRESH_RESET;

    localparam int          KEEP_DEPTH      = gkt_pkg::MAX_SURVIVORS_DEF;
    localparam int          SETTLE_CYCLES   = 340;
    localparam int          QUIET_LIMIT     = 20000;
    localparam int          HOLD_CYCLES     = 1500;
    localparam int          FILLER_POINTS   = 20;
    localparam bit [32:0]   THR_ZERO        = 33'd0;
    localparam bit [32:0]   THR_MAX         = 33'h1_FFFF_FFFF;
    localparam bit [32:0]   THR_FAR_CORNER  = 33'h1_FFFC_0002;  // 2 * 65535^2

    typedef struct packed {
        bit [COORD_W-1:0] x;
        bit [COORD_W-1:0] y;
        bit [INDEX_W-1:0] idx;
        bit               full;
    } t_kept;

    typedef struct packed {
        bit               cfg;
        bit [32:0]        thr;
        bit               st;
        bit [COORD_W-1:0] x;
        bit [COORD_W-1:0] y;
        bit               typed;
        bit               keep;
        bit [INDEX_W-1:0] idx;
        bit               full;
    } t_probe_row;

    // cfg thr st x y | typed keep idx full
    localparam t_probe_row PROBE_ROWS [22] = '{
        '{1'b0, THR_ZERO,       1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'd1, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'd2, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'h00A0, 16'h0000, 1'b1, 1'b1, 16'd3, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'h0000, 16'h009F, 1'b1, 1'b0, 16'd4, 1'b0},
        '{1'b0, THR_ZERO,       1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'd1, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'd2, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b1, THR_ZERO,       1'b1, 16'h1234, 16'h5678, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'h1234, 16'h5678, 1'b1, 1'b1, 16'd1, 1'b0},
        '{1'b0, THR_ZERO,       1'b0, 16'hA5A5, 16'h5A5A, 1'b1, 1'b1, 16'd2, 1'b0},
        '{1'b1, THR_MAX,        1'b1, 16'h0005, 16'h0005, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, THR_MAX,        1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'd1, 1'b0},
        '{1'b0, THR_MAX,        1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'd2, 1'b0},
        '{1'b1, THR_FAR_CORNER, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, THR_FAR_CORNER, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'd1, 1'b0},
        '{1'b0, THR_FAR_CORNER, 1'b0, 16'hFFFF, 16'hFFFE, 1'b1, 1'b0, 16'd2, 1'b0},
        '{1'b0, THR_FAR_CORNER, 1'b0, 16'h0000, 16'h0001, 1'b1, 1'b0, 16'd3, 1'b0},
        '{1'b1, THRESH_RESET,   1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, THRESH_RESET,   1'b0, 16'h8060, 16'h8080, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, THRESH_RESET,   1'b0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'd2, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THRESH_W-1:0] cfg_wr_data;

    gkt_point_if pt_if ();
    gkt_kept_if  kept_if ();

    greedy_keypoint_thinning_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_pt          (pt_if),
        .o_kept        (kept_if)
    );

    // Predictor state
    bit [32:0]         thin_threshold;
    bit [ENTRY_W-1:0]  survivor_xy [KEEP_DEPTH];
    int                survivor_cnt;
    bit [INDEX_W-1:0]  set_pos;

    t_kept expected_kept [$];
    t_kept want_kept;
    t_kept got_kept;

    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold;
    int quiet_cycles;
    int mismatches;

    always #5 clk = ~clk;

    function automatic void predict_thinning(input bit st, input bit [COORD_W-1:0] x,
                                             input bit [COORD_W-1:0] y,
                                             output bit kept, output t_kept res);
        bit [COORD_W-1:0] sx;
        bit [COORD_W-1:0] sy;
        bit [COORD_W-1:0] dx;
        bit [COORD_W-1:0] dy;
        bit [DIST_W-1:0]  d2;
        if (st) begin
            survivor_cnt = 0;
            set_pos      = '0;
        end
        res.x    = x;
        res.y    = y;
        res.idx  = set_pos;
        res.full = 1'b0;
        if (set_pos != INDEX_MAX)
            set_pos++;
        kept = 1'b1;
        for (int i = 0; i < survivor_cnt; i++) begin
            sx = survivor_xy[i][ENTRY_W-1:COORD_W];
            sy = survivor_xy[i][COORD_W-1:0];
            dx = (x >= sx) ? x - sx : sx - x;
            dy = (y >= sy) ? y - sy : sy - y;
            d2 = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
            if (d2 < {1'b0, thin_threshold}) begin
                kept = 1'b0;
                break;
            end
        end
        if (kept) begin
            if (survivor_cnt < KEEP_DEPTH) begin
                survivor_xy[survivor_cnt] = {x, y};
                survivor_cnt++;
            end else begin
                res.full = 1'b1;
            end
        end
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    // Append one expected kept point to the scoreboard.
    task automatic queue_kept(input t_kept r);
        expected_kept.insert(expected_kept.size(), r);
    endtask

    // Offer one point request and return the predicted outcome once it is taken.
    task automatic offer_point(input bit st, input bit [COORD_W-1:0] x,
                               input bit [COORD_W-1:0] y,
                               output bit kept, output t_kept res);
        while ($urandom_range(99) < src_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pt_if.valid     <= 1'b1;
        pt_if.start_req <= st;
        pt_if.pos_x     <= x;
        pt_if.pos_y     <= y;
        @(posedge clk);
        while (!pt_if.ready)
            @(posedge clk);
        predict_thinning(st, x, y, kept, res);
    endtask

    // Hold the sender until every kept point is out and any suppressed one has drained.
    task automatic wait_block_idle();
        pt_if.valid <= 1'b0;
        while (expected_kept.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_threshold(input bit [32:0] thr);
        wait_block_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        thin_threshold  = thr;
    endtask

    task automatic run_random_sets(input int n_points, input int max_set);
        int               set_left;
        int               sel;
        bit               st;
        bit [COORD_W-1:0] bx;
        bit [COORD_W-1:0] by;
        bit [COORD_W-1:0] x;
        bit [COORD_W-1:0] y;
        bit               kept;
        t_kept            res;
        set_left = 0;
        bx = '0;
        by = '0;
        for (int i = 0; i < n_points; i++) begin
            st = 1'b0;
            // open a new set when the current one runs out, now and then early
            if (set_left == 0 || $urandom_range(49) == 0) begin
                st       = 1'b1;
                set_left = $urandom_range(1, max_set);
                bx       = COORD_W'($urandom_range(0, 16'hF7FF));
                by       = COORD_W'($urandom_range(0, 16'hF7FF));
            end
            set_left--;
            sel = $urandom_range(99);
            if (sel < 60) begin
                x = bx + COORD_W'($urandom_range(0, 2047));
                y = by + COORD_W'($urandom_range(0, 2047));
            end else if (sel < 90) begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end else begin
                x = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            offer_point(st, x, y, kept, res);
            if (kept)
                queue_kept(res);
        end
    endtask

    // Score kept points and drive the receiver's ready.
    always @(posedge clk) begin
        if (rst_n && kept_if.valid && kept_if.ready) begin
            got_kept = '{kept_if.kept_x, kept_if.kept_y, kept_if.point_index,
                         kept_if.store_full};
            if (expected_kept.size() == 0) begin
                note_mismatch($sformatf("unexpected kept point x=%h y=%h idx=%0d full=%0b",
                              got_kept.x, got_kept.y, got_kept.idx, got_kept.full));
            end else begin
                want_kept = expected_kept.pop_front();
                if (kept_if.kept_x !== want_kept.x || kept_if.kept_y !== want_kept.y ||
                    kept_if.point_index !== want_kept.idx ||
                    kept_if.store_full !== want_kept.full)
                    note_mismatch($sformatf({"kept point mismatch: expected x=%h y=%h idx=%0d",
                                  " full=%0b, got x=%h y=%h idx=%0d full=%0b"},
                                  want_kept.x, want_kept.y, want_kept.idx, want_kept.full,
                                  kept_if.kept_x, kept_if.kept_y, kept_if.point_index,
                                  kept_if.store_full));
            end
        end
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            kept_if.ready <= 1'b0;
        end else begin
            kept_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((pt_if.valid && pt_if.ready) || (kept_if.valid && kept_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_greedy_keypoint_thinning_top failed");
            $finish;
        end
    end

    initial begin
        bit    kept;
        t_kept res;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        pt_if.valid     = 1'b0;
        pt_if.start_req = 1'b0;
        pt_if.pos_x     = '0;
        pt_if.pos_y     = '0;
        sink_hold       = 0;
        mismatches      = 0;
        thin_threshold  = THRESH_RESET;
        survivor_cnt    = 0;
        set_pos         = '0;
        src_idle_pct    = 8;
        sink_idle_pct   = 86;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (PROBE_ROWS[r]) begin
            if (PROBE_ROWS[r].cfg)
                load_threshold(PROBE_ROWS[r].thr);
            offer_point(PROBE_ROWS[r].st, PROBE_ROWS[r].x, PROBE_ROWS[r].y, kept, res);
            if (PROBE_ROWS[r].typed) begin
                if (PROBE_ROWS[r].keep)
                    queue_kept('{PROBE_ROWS[r].x, PROBE_ROWS[r].y,
                                 PROBE_ROWS[r].idx, PROBE_ROWS[r].full});
            end else if (kept) begin
                queue_kept(res);
            end
        end

        // zero threshold keeps everything, so long sets overflow the store
        load_threshold(THR_ZERO);
        run_random_sets(100, 90);
        load_threshold(THRESH_RESET);
        run_random_sets(100, 80);

        src_idle_pct  = 86;
        sink_idle_pct = 8;
        load_threshold({1'b0, 32'($urandom_range(1, 1 << 22))});
        sink_hold = HOLD_CYCLES;    // let the block back up against a stalled receiver
        run_random_sets(120, 70);
        load_threshold(THR_MAX);
        run_random_sets(60, 4);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_threshold({1'(($urandom_range(1))), 32'($urandom)});
        run_random_sets(40, 30);
        load_threshold(33'd102400);
        run_random_sets(90, 90);
        wait_block_idle();
        run_random_sets(90, 90);

        // Against the origin only the far corner clears this threshold.
        load_threshold(THR_FAR_CORNER);
        offer_point(1'b1, 16'h0000, 16'h0000, kept, res);
        if (kept)
            queue_kept(res);
        for (int i = 0; i < FILLER_POINTS; i++) begin
            offer_point(1'b0, COORD_W'($urandom_range(0, 16'hFFFE)), COORD_W'($urandom),
                        kept, res);
            if (kept)
                queue_kept(res);
        end
        offer_point(1'b0, 16'hFFFF, 16'hFFFF, kept, res);
        if (kept)
            queue_kept(res);
        offer_point(1'b0, 16'hFFFF, 16'hFFFF, kept, res);
        if (kept)
            queue_kept(res);

        wait_block_idle();
        if (mismatches == 0)
            $display("tb_greedy_keypoint_thinning_top passed");
        else
            $display("tb_greedy_keypoint_thinning_top failed");
        $finish;
    end

endmodule
